FILE: src/stereo_voice_mixer_clip_core_defines.svh
// ----------------------------------------------------------------------------
// stereo voice mixer assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef STEREO_VOICE_MIXER_CLIP_CORE_DEFINES_SVH
`define STEREO_VOICE_MIXER_CLIP_CORE_DEFINES_SVH

// assertion that is muted while reset is high
`define SVMC_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion that also holds across reset
`define SVMC_ASSERT_ALL(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/svmc_pkg.sv
// ----------------------------------------------------------------------------
// svmc_pkg
// types, constants and arithmetic helpers of the stereo voice mixer
// ----------------------------------------------------------------------------
package svmc_pkg;

   localparam int S_W    = 16;  // sample width
   localparam int G_W    = 16;  // gain width
   localparam int CLIP_W = 15;  // clip level width
   localparam int T_W    = 19;  // scaled working value
   localparam int P_W    = 36;  // product width
   localparam int ACC_W  = 24;  // accumulator width
   localparam int IDX_W  = 2;   // register index width

   localparam logic [IDX_W-1:0] REG_MASTER_GAIN = 2'd0;
   localparam logic [IDX_W-1:0] REG_PEAK_GAIN   = 2'd1;
   localparam logic [IDX_W-1:0] REG_CLIP_LEVEL  = 2'd2;

   localparam logic [G_W-1:0]    MASTER_GAIN_RST = 16'd22938;
   localparam logic [G_W-1:0]    PEAK_GAIN_RST   = 16'd22938;
   localparam logic [CLIP_W-1:0] CLIP_LEVEL_RST  = 15'd22937;
   localparam logic [G_W-1:0]    PCM_SCALE       = 16'd32767;

   localparam logic signed [P_W-1:0]   Q15_BIAS = 36'sd32767;
   localparam logic signed [ACC_W:0]   ACC_MAX  = 25'sd8388607;
   localparam logic signed [ACC_W:0]   ACC_MIN  = -25'sd8388608;

   typedef enum logic [1:0] {
      GS_MASTER,
      GS_VOICE,
      GS_PEAK,
      GS_PCM
   } gain_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SHIFT,
      ST_ACC,
      ST_CLIP,
      ST_FMUL,
      ST_FSHIFT
   } state_type;

   typedef struct packed {
      logic         load;
      logic         mul;
      logic         shift;
      logic         acc;
      logic         clip;
      logic         out_load;
      gain_sel_type gain_sel;
   } dp_cmd_type;

   // shift a product back to q15, truncating toward zero
   function automatic logic signed [T_W-1:0] q15_trunc(input logic signed [P_W-1:0] p);
      logic signed [P_W-1:0] bias;
      logic signed [P_W-1:0] adj;
      bias = p[P_W-1] ? Q15_BIAS : '0;
      adj = p + bias;
      q15_trunc = adj[T_W+14:15];
   endfunction

   function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] sum,
                                                       input logic signed [T_W-1:0] t);
      logic signed [ACC_W:0] s;
      s = (ACC_W+1)'(sum) + (ACC_W+1)'(t);
      if (s > ACC_MAX) begin
         s = ACC_MAX;
      end else if (s < ACC_MIN) begin
         s = ACC_MIN;
      end
      sat_add = s[ACC_W-1:0];
   endfunction

   function automatic logic signed [T_W-1:0] clip_sum(input logic signed [ACC_W-1:0] sum,
                                                      input logic [CLIP_W-1:0] lim);
      logic signed [ACC_W-1:0] lim_s;
      logic signed [ACC_W-1:0] c;
      lim_s = signed'({{(ACC_W-CLIP_W){1'b0}}, lim});
      if (sum > lim_s) begin
         c = lim_s;
      end else if (sum < -lim_s) begin
         c = -lim_s;
      end else begin
         c = sum;
      end
      clip_sum = c[T_W-1:0];
   endfunction

endpackage

FILE: src/stereo_voice_mixer_clip_core.sv
// each voice request that does not close the frame runs three multiply and
// shift steps through the shared per-channel multiplier, then the accumulate.
// a request with tlast then runs clip and pcm scale before the result is
// registered as valid; a stalled result holds off only the next frame end.
// reset is synchronous: gains and clip level go to their defaults, sums and
// voice count to zero, no result pending.
// ----------------------------------------------------------------------------
// stereo_voice_mixer_clip_core
// mixes one stereo output frame from a run of voice requests with clipping
// ----------------------------------------------------------------------------
module stereo_voice_mixer_clip_core
   import svmc_pkg::*;
#(
   parameter int MAX_VOICES = 64
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [G_W-1:0]    csr_wdata,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [47:0]       req_tdata,   // left_sample, right_sample, voice_gain
   input  logic              req_tuser,   // voice_active
   input  logic              req_tlast,   // last_voice
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata    // left_out, right_out
);

   dp_cmd_type            cmd;
   logic signed [S_W-1:0] left_out;
   logic signed [S_W-1:0] right_out;

   svmc_ctrl #(
      .MAX_VOICES (MAX_VOICES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_active (req_tuser),
      .req_last   (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   svmc_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .left_sample  (signed'(req_tdata[15:0])),
      .right_sample (signed'(req_tdata[31:16])),
      .voice_gain   (req_tdata[47:32]),
      .cmd          (cmd),
      .left_out     (left_out),
      .right_out    (right_out)
   );

   assign rsp_tdata = {right_out, left_out};

endmodule

FILE: src/svmc_datapath.sv
// ----------------------------------------------------------------------------
// svmc_datapath
// gain registers, shared per-channel multiplier, accumulators and output
// ----------------------------------------------------------------------------
module svmc_datapath
   import svmc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [IDX_W-1:0]        csr_index,
   input  logic [G_W-1:0]          csr_wdata,
   input  logic signed [S_W-1:0]   left_sample,
   input  logic signed [S_W-1:0]   right_sample,
   input  logic [G_W-1:0]          voice_gain,
   input  dp_cmd_type              cmd,
   output logic signed [S_W-1:0]   left_out,
   output logic signed [S_W-1:0]   right_out
);

   logic [G_W-1:0]            master_ff, master_in;
   logic [G_W-1:0]            peak_ff, peak_in;
   logic [CLIP_W-1:0]         clip_ff, clip_in;
   logic [G_W-1:0]            vgain_ff, vgain_in;
   logic signed [T_W-1:0]     l_t_ff, l_t_in, r_t_ff, r_t_in;
   logic signed [P_W-1:0]     l_p_ff, l_p_in, r_p_ff, r_p_in;
   logic signed [ACC_W-1:0]   l_sum_ff, l_sum_in, r_sum_ff, r_sum_in;
   logic signed [S_W-1:0]     l_out_ff, l_out_in, r_out_ff, r_out_in;
   logic [G_W-1:0]            gain;
   logic signed [G_W:0]       gain_s;
   logic signed [T_W-1:0]     l_trunc, r_trunc;

   always_comb begin
      master_in = master_ff;
      peak_in   = peak_ff;
      clip_in   = clip_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_MASTER_GAIN: master_in = csr_wdata;
            REG_PEAK_GAIN:   peak_in   = csr_wdata;
            REG_CLIP_LEVEL:  clip_in   = csr_wdata[CLIP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cmd.gain_sel)
         GS_MASTER: gain = master_ff;
         GS_VOICE:  gain = vgain_ff;
         GS_PEAK:   gain = peak_ff;
         GS_PCM:    gain = PCM_SCALE;
         default:   gain = PCM_SCALE;
      endcase
      gain_s = signed'({1'b0, gain});
   end

   assign l_trunc = q15_trunc(l_p_ff);
   assign r_trunc = q15_trunc(r_p_ff);

   always_comb begin
      vgain_in = cmd.load ? voice_gain : vgain_ff;
      l_p_in   = cmd.mul ? l_t_ff * gain_s : l_p_ff;
      r_p_in   = cmd.mul ? r_t_ff * gain_s : r_p_ff;
      l_t_in   = l_t_ff;
      r_t_in   = r_t_ff;
      if (cmd.load) begin
         l_t_in = T_W'(left_sample);
         r_t_in = T_W'(right_sample);
      end else if (cmd.shift) begin
         l_t_in = l_trunc;
         r_t_in = r_trunc;
      end else if (cmd.clip) begin
         l_t_in = clip_sum(l_sum_ff, clip_ff);
         r_t_in = clip_sum(r_sum_ff, clip_ff);
      end
      l_sum_in = l_sum_ff;
      r_sum_in = r_sum_ff;
      if (cmd.clip) begin
         l_sum_in = '0;
         r_sum_in = '0;
      end else if (cmd.acc) begin
         l_sum_in = sat_add(l_sum_ff, l_t_ff);
         r_sum_in = sat_add(r_sum_ff, r_t_ff);
      end
      l_out_in = cmd.out_load ? l_trunc[S_W-1:0] : l_out_ff;
      r_out_in = cmd.out_load ? r_trunc[S_W-1:0] : r_out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff <= MASTER_GAIN_RST;
         peak_ff   <= PEAK_GAIN_RST;
         clip_ff   <= CLIP_LEVEL_RST;
         l_sum_ff  <= '0;
         r_sum_ff  <= '0;
      end else begin
         master_ff <= master_in;
         peak_ff   <= peak_in;
         clip_ff   <= clip_in;
         l_sum_ff  <= l_sum_in;
         r_sum_ff  <= r_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      vgain_ff <= vgain_in;
      l_t_ff   <= l_t_in;
      r_t_ff   <= r_t_in;
      l_p_ff   <= l_p_in;
      r_p_ff   <= r_p_in;
      l_out_ff <= l_out_in;
      r_out_ff <= r_out_in;
   end

   assign left_out  = l_out_ff;
   assign right_out = r_out_ff;

endmodule

FILE: src/svmc_ctrl.sv
// ----------------------------------------------------------------------------
// svmc_ctrl
// sequencer for the gain steps, voice counter and result handshake
// ----------------------------------------------------------------------------
module svmc_ctrl
   import svmc_pkg::*;
#(
   parameter int MAX_VOICES = 64
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       req_active,
   input  logic       req_last,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd
);

   localparam int CNT_W = $clog2(MAX_VOICES + 1);

   state_type          state_ff, state_in;
   gain_sel_type       step_ff, step_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               active_ff, active_in;
   logic               last_ff, last_in;
   logic               out_valid_ff, out_valid_in;
   logic               room;
   logic               out_free;

   assign room     = count_ff < CNT_W'(MAX_VOICES);
   assign out_free = !out_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_MUL;
         ST_MUL:    state_in = ST_SHIFT;
         ST_SHIFT:  state_in = (step_ff == GS_PEAK) ? ST_ACC : ST_MUL;
         ST_ACC:    state_in = last_ff ? ST_CLIP : ST_IDLE;
         ST_CLIP:   state_in = ST_FMUL;
         ST_FMUL:   state_in = ST_FSHIFT;
         ST_FSHIFT: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and counters
   always_comb begin
      cmd          = '0;
      cmd.gain_sel = step_ff;
      req_tready   = 1'b0;
      step_in      = step_ff;
      count_in     = count_ff;
      active_in    = active_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load  = 1'b1;
               active_in = req_active;
               last_in   = req_last;
               step_in   = GS_MASTER;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            step_in   = gain_sel_type'(step_ff + 2'd1);
         end
         ST_ACC: begin
            if (room) begin
               count_in = count_ff + CNT_W'(1);
               cmd.acc  = active_ff;
            end
         end
         ST_CLIP: begin
            cmd.clip = 1'b1;
            count_in = '0;
         end
         ST_FMUL: begin
            cmd.mul      = 1'b1;
            cmd.gain_sel = GS_PCM;
         end
         ST_FSHIFT: begin
            cmd.gain_sel = GS_PCM;
            if (out_free) begin
               cmd.out_load = 1'b1;
               out_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= GS_MASTER;
         count_ff     <= '0;
         active_ff    <= 1'b0;
         last_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         last_ff      <= last_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

FILE: src/svmc_checker.sv
// ----------------------------------------------------------------------------
// svmc_checker
// port-level checks of the stereo voice mixer, bound to the top level
// ----------------------------------------------------------------------------
`include "stereo_voice_mixer_clip_core_defines.svh"

module svmc_checker
   import svmc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [31:0]       rsp_tdata
);

   `SVMC_ASSERT_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped while stalled")

   `SVMC_ASSERT_ALL(a_rsp_reset, clock, reset |=> !rsp_tvalid, "result pending after reset")

   `SVMC_ASSERT_RST(a_busy, clock, reset, req_tvalid && req_tready |=> !req_tready, "request taken while busy")

   `SVMC_ASSERT_RST(a_clip_range, clock, reset, rsp_tvalid |-> (rsp_tdata[15:0] != 16'h8000) && (rsp_tdata[31:16] != 16'h8000), "result outside clip range")

endmodule

bind stereo_voice_mixer_clip_core svmc_checker u_svmc_checker (.*);
